/* design/assert_macros.svh */
// Assertion macros used by the checker of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

/* design/bdq_pkg.sv */
// Package: types, codes and default sizes for the bounded deque with search.
package bdq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int CNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);
	localparam int DATA_W        = 32;
	localparam int MODE_W        = 3;
	localparam int STAT_W        = 2;

	// Request operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_BACK  = 3'd1,
		MODE_REM_FRONT = 3'd2,
		MODE_REM_BACK  = 3'd3,
		MODE_REPLACE   = 3'd4,
		MODE_SEARCH    = 3'd5,
		MODE_DUMP      = 3'd6
	} mode_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_BADPOS = 2'd3
	} stat_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_DECODE = 2'd1,
		S_STEP   = 2'd2
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;        // latch the request transaction
		logic apply;       // execute single-result op and load its result
		logic scan_init;   // start a walk: read offset zero
		logic scan_step;   // read next offset, fold compare into found flag
		logic emit_entry;  // load one dump entry into the output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_scan;     // search or dump on a non-empty list
		logic is_dump;
		logic at_end;      // all entries have been read
		logic out_free;    // output register can take a result this cycle
	} sts_t;

endpackage

/* design/bdq_req_if.sv */
// Request channel interface: operation, value and position.
interface bdq_req_if #(
	parameter int CNT_W = bdq_pkg::CNT_W_DEFAULT
);
	logic                      valid;
	logic                      ready;
	logic [bdq_pkg::MODE_W-1:0] mode;
	logic signed [bdq_pkg::DATA_W-1:0] value;
	logic [CNT_W-1:0]          position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

/* design/bdq_rsp_if.sv */
// Result channel interface: entry value, found flag, count, status and last mark.
interface bdq_rsp_if #(
	parameter int CNT_W = bdq_pkg::CNT_W_DEFAULT
);
	logic                      valid;
	logic                      ready;
	logic signed [bdq_pkg::DATA_W-1:0] entry_value;
	logic                      found;
	logic [CNT_W-1:0]          entry_count;
	logic [bdq_pkg::STAT_W-1:0] status;
	logic                      last;

	modport source (output valid, output entry_value, output found, output entry_count,
		output status, output last, input ready);
	modport sink   (input valid, input entry_value, input found, input entry_count,
		input status, input last, output ready);
endinterface

/* design/bounded_deque_with_search.sv */
// Top level: bounded deque of signed 32-bit entries with search and dump.
// Channels: req (mode, value, position) and rsp (entry_value, found,
// entry_count, status, last), both valid/ready; a transaction moves on a
// rising edge with valid and ready high.
// One request is worked at a time. req.ready is high only while the block is
// idle; it drops after each accepted transaction until that request is worked.
// Insert, remove, replace and any request on an empty list: the result is
// loaded from the decode state once the output register is free, and the
// block returns to idle with it, ready for the next request.
// Search walks the stored entries through the single memory read port, one
// entry a cycle, and loads its result once the walk ends and the output is free.
// Dump gives one result per entry, one a cycle while the output is free, the
// last marked with last; the decode state reads the first entry for it.
// Results sit in an output register; a new request is taken while a result
// waits there. A stalled receiver holds a dump walk and the output register,
// and nothing is lost or repeated.
// Reset (arst_n low) empties the list: head and count clear at once, the
// entry storage is not cleared, and no result is pending.
module bounded_deque_with_search #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	bdq_pkg::cmd_t cmd;
	bdq_pkg::sts_t sts;

	// Sequencer
	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and result path
	bdq_dpath #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_mode        (req.mode),
		.req_value       (req.value),
		.req_position    (req.position),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_entry_value (rsp.entry_value),
		.rsp_found       (rsp.found),
		.rsp_entry_count (rsp.entry_count),
		.rsp_status      (rsp.status),
		.rsp_last        (rsp.last)
	);

endmodule

/* design/bdq_ctrl.sv */
// Controller state machine: request acceptance, list walk sequencing, result emission.
module bdq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  bdq_pkg::sts_t   sts,
	output bdq_pkg::cmd_t   cmd
);

	bdq_pkg::state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bdq_pkg::S_IDLE: begin
				if (req_valid) state_nx = bdq_pkg::S_DECODE;
			end
			bdq_pkg::S_DECODE: begin
				if (sts.is_scan) state_nx = bdq_pkg::S_STEP;
				else if (sts.out_free) state_nx = bdq_pkg::S_IDLE;
			end
			bdq_pkg::S_STEP: begin
				if (sts.at_end && sts.out_free) state_nx = bdq_pkg::S_IDLE;
			end
			default: state_nx = bdq_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			bdq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			bdq_pkg::S_DECODE: begin
				if (sts.is_scan) cmd.scan_init = 1'b1;
				else cmd.apply = sts.out_free;
			end
			bdq_pkg::S_STEP: begin
				if (sts.is_dump) begin
					// one entry per free output slot; fetch the next alongside
					cmd.emit_entry = sts.out_free;
					cmd.scan_step  = sts.out_free && !sts.at_end;
				end else if (sts.at_end) begin
					cmd.apply = sts.out_free;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

/* design/bdq_dpath.sv */
// Datapath: entry memory, head and count registers, walk index, output register.
module bdq_dpath #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdq_pkg::cmd_t                     cmd,
	output bdq_pkg::sts_t                     sts,
	input  logic [bdq_pkg::MODE_W-1:0]        req_mode,
	input  logic signed [bdq_pkg::DATA_W-1:0] req_value,
	input  logic [CNT_W-1:0]                  req_position,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic signed [bdq_pkg::DATA_W-1:0] rsp_entry_value,
	output logic                              rsp_found,
	output logic [CNT_W-1:0]                  rsp_entry_count,
	output logic [bdq_pkg::STAT_W-1:0]        rsp_status,
	output logic                              rsp_last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int SUM_W = CNT_W + 1;

	// Ring position of an offset from the head; the sum stays below twice DEPTH
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] h,
		input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(h) + SUM_W'(off);
		if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

	logic [bdq_pkg::DATA_W-1:0] mem [DEPTH];
	logic [bdq_pkg::DATA_W-1:0] rd_q;

	bdq_pkg::mode_t             mode_q;
	logic [bdq_pkg::DATA_W-1:0] value_q;
	logic [CNT_W-1:0]           pos_q;
	logic [IDX_W-1:0]           head_q, head_nx;
	logic [CNT_W-1:0]           count_q, count_nx;
	logic [CNT_W-1:0]           idx_q;
	logic                       found_q, found_bit;
	logic                       hit, full, empty;
	logic                       we, rd_en;
	logic [IDX_W-1:0]           waddr, raddr;
	bdq_pkg::stat_t             stat;

	logic                       out_valid_q;
	logic [bdq_pkg::DATA_W-1:0] out_value_q;
	logic                       out_found_q;
	logic [CNT_W-1:0]           out_count_q;
	bdq_pkg::stat_t             out_stat_q;
	logic                       out_last_q;

	assign hit   = (rd_q == value_q);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Single-result operations: status, found bit, memory write and next head/count
	always_comb begin
		head_nx   = head_q;
		count_nx  = count_q;
		we        = 1'b0;
		waddr     = head_q;
		stat      = bdq_pkg::STAT_OK;
		found_bit = 1'b0;
		case (mode_q)
			bdq_pkg::MODE_INS_FRONT: begin
				if (full) begin
					stat = bdq_pkg::STAT_FULL;
				end else begin
					head_nx  = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
					waddr    = head_nx;
					we       = 1'b1;
					count_nx = count_q + CNT_W'(1);
				end
			end
			bdq_pkg::MODE_INS_BACK: begin
				if (full) begin
					stat = bdq_pkg::STAT_FULL;
				end else begin
					waddr    = slot(head_q, count_q);
					we       = 1'b1;
					count_nx = count_q + CNT_W'(1);
				end
			end
			bdq_pkg::MODE_REM_FRONT: begin
				if (empty) begin
					stat = bdq_pkg::STAT_EMPTY;
				end else begin
					head_nx  = slot(head_q, CNT_W'(1));
					count_nx = count_q - CNT_W'(1);
				end
			end
			bdq_pkg::MODE_REM_BACK: begin
				if (empty) stat = bdq_pkg::STAT_EMPTY;
				else count_nx = count_q - CNT_W'(1);
			end
			bdq_pkg::MODE_REPLACE: begin
				if (empty) begin
					stat = bdq_pkg::STAT_EMPTY;
				end else if (pos_q == '0 || pos_q > count_q) begin
					stat = bdq_pkg::STAT_BADPOS;
				end else begin
					waddr = slot(head_q, pos_q - CNT_W'(1));
					we    = 1'b1;
				end
			end
			bdq_pkg::MODE_SEARCH: begin
				if (empty) stat = bdq_pkg::STAT_EMPTY;
				else found_bit = found_q | hit;
			end
			bdq_pkg::MODE_DUMP: begin
				if (empty) stat = bdq_pkg::STAT_EMPTY;
			end
			default: ;
		endcase
	end

	// Walk read port
	assign rd_en = cmd.scan_init || cmd.scan_step;
	assign raddr = slot(head_q, cmd.scan_init ? '0 : idx_q);

	// Entry memory
	always_ff @(posedge clk) begin
		if (cmd.apply && we) mem[waddr] <= value_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[raddr];
	end

	// Request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= bdq_pkg::mode_t'(req_mode);
			value_q <= req_value;
			pos_q   <= req_position;
		end
	end

	// List control and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				head_q  <= head_nx;
				count_q <= count_nx;
			end
			if (cmd.scan_init) begin
				idx_q   <= CNT_W'(1);
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				idx_q   <= idx_q + CNT_W'(1);
				found_q <= found_q | hit;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply || cmd.emit_entry) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			out_value_q <= '0;
			out_found_q <= found_bit;
			out_count_q <= count_nx;
			out_stat_q  <= stat;
			out_last_q  <= 1'b1;
		end else if (cmd.emit_entry) begin
			out_value_q <= rd_q;
			out_found_q <= 1'b0;
			out_count_q <= count_q;
			out_stat_q  <= bdq_pkg::STAT_OK;
			out_last_q  <= (idx_q == count_q);
		end
	end

	assign sts.is_scan  = !empty && (mode_q == bdq_pkg::MODE_SEARCH || mode_q == bdq_pkg::MODE_DUMP);
	assign sts.is_dump  = (mode_q == bdq_pkg::MODE_DUMP);
	assign sts.at_end   = (idx_q == count_q);
	assign sts.out_free = !out_valid_q || rsp_ready;

	assign rsp_valid       = out_valid_q;
	assign rsp_entry_value = out_value_q;
	assign rsp_found       = out_found_q;
	assign rsp_entry_count = out_count_q;
	assign rsp_status      = out_stat_q;
	assign rsp_last        = out_last_q;

endmodule

/* design/bdq_checker.sv */
// Port-level checker for the bounded deque, bound to the top level.
`include "assert_macros.svh"

module bdq_checker #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [bdq_pkg::DATA_W-1:0]  rsp_entry_value,
	input logic                        rsp_found,
	input logic [CNT_W-1:0]            rsp_entry_count,
	input logic [bdq_pkg::STAT_W-1:0]  rsp_status,
	input logic                        rsp_last
);

	logic [bdq_pkg::DATA_W+CNT_W+bdq_pkg::STAT_W+1:0] rsp_word;
	logic stat_ok, stat_empty;

	assign rsp_word   = {rsp_entry_value, rsp_found, rsp_entry_count, rsp_status, rsp_last};
	assign stat_ok    = (rsp_status == bdq_pkg::STAT_OK);
	assign stat_empty = (rsp_status == bdq_pkg::STAT_EMPTY);

	// count never exceeds capacity
	`ASSERT_IMPL(a_count_bound, clk, arst_n, rsp_valid, rsp_entry_count <= CNT_W'(DEPTH))
	// an error result always closes its request
	`ASSERT_IMPL(a_err_last, clk, arst_n, rsp_valid && !stat_ok, rsp_last)
	// empty status only with an empty list, and found only on success
	`ASSERT_IMPL(a_empty_cnt, clk, arst_n, rsp_valid && stat_empty, rsp_entry_count == '0)
	`ASSERT_IMPL(a_found_ok, clk, arst_n, rsp_valid && rsp_found, stat_ok && rsp_entry_value == '0)
	// stalled result holds
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule

bind bounded_deque_with_search bdq_checker #(
	.DEPTH (DEPTH)
) u_bdq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_entry_value (rsp.entry_value),
	.rsp_found       (rsp.found),
	.rsp_entry_count (rsp.entry_count),
	.rsp_status      (rsp.status),
	.rsp_last        (rsp.last)
);
